// ===== rtl/fss_pkg.sv =====
// ----------------------------------------------------------------------------
// fss_pkg: shared types, constants and table builder for the stepped-sine sweep
// Register indexes, reset values, controller state and command types, and the
// quarter-wave cosine function used to build the lookup table at elaboration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fss_pkg;

	localparam int PHASE_INDEX_BITS_DEF = 10;
	localparam int SAMPLE_WIDTH_DEF     = 16;

	localparam int TIME_W     = 32;
	localparam int FREQ_W     = 32;
	localparam int CPF_W      = 16;
	localparam int SMP_W      = 16;
	localparam int COS_W      = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_START_FREQ = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_FREQ  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_STEP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CYC_PER_F  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 3'd6;

	localparam logic [FREQ_W-1:0] START_FREQ_RST = 32'd65536;
	localparam logic [FREQ_W-1:0] STOP_FREQ_RST  = 32'd6553600;
	localparam logic [FREQ_W-1:0] FREQ_STEP_RST  = 32'd65536;
	localparam logic [CPF_W-1:0]  CYC_PER_F_RST  = 16'd10;
	localparam logic [SMP_W-1:0]  AMPLITUDE_RST  = 16'd4096;
	localparam logic [SMP_W-1:0]  BIAS_RST       = 16'd0;
	localparam logic [TIME_W-1:0] START_TIME_RST = 32'd0;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ELAP,
		ST_MUL,
		ST_ROM,
		ST_SCALE,
		ST_FIN
	} fss_state_t;

	typedef struct packed {
		logic load;
		logic elap;
		logic mul;
		logic rom;
		logic scale;
		logic fin;
	} fss_cmd_t;

	// cos(pi/2 * j/quarter) in Q1.14 from a Q2.30 Taylor series
	function automatic logic [COS_W-1:0] fss_quarter_cos(input int unsigned j,
			input int unsigned p);
		logic [63:0]        theta;
		logic [63:0]        t2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        rnd;
		theta = (64'd2 * PI_Q30 * 64'(j)) >> p;
		t2    = (theta * theta) >> 30;
		term  = 64'd1 << 30;
		sum   = $signed(term);
		for (int n = 1; n <= 9; n++) begin
			term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
			if ((n % 2) == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		rnd = (64'(sum) + 64'd32768) >> 16;
		if (rnd > 64'd16384) begin
			rnd = 64'd16384;
		end
		return rnd[COS_W-1:0];
	endfunction

endpackage

// ===== rtl/fss_cos_rom.sv =====
// ----------------------------------------------------------------------------
// fss_cos_rom: quarter-wave cosine table
// Holds cos over the first quadrant inclusive of the end point, magnitude in
// Q1.14, built at elaboration; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fss_cos_rom #(
	parameter int PHASE_INDEX_BITS = fss_pkg::PHASE_INDEX_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [PHASE_INDEX_BITS-2:0]    addr,
	output logic [fss_pkg::COS_W-1:0]      data
);
	import fss_pkg::*;

	localparam int DEPTH = (1 << (PHASE_INDEX_BITS - 2)) + 1;

	logic [COS_W-1:0] tab [0:DEPTH-1];
	logic [COS_W-1:0] data_q;

	for (genvar g = 0; g < DEPTH; g++) begin : g_tab
		assign tab[g] = fss_quarter_cos(g, PHASE_INDEX_BITS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= tab[addr];
		end
	end

	assign data = data_q;

endmodule

// ===== rtl/fss_datapath.sv =====
// ----------------------------------------------------------------------------
// fss_datapath: sweep arithmetic, configuration and sweep state
// Elapsed time, phase multiply, cosine lookup, amplitude scaling, bias and
// saturation, and the frequency stepping, committed with the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fss_datapath #(
	parameter int PHASE_INDEX_BITS = fss_pkg::PHASE_INDEX_BITS_DEF,
	parameter int SAMPLE_WIDTH     = fss_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fss_pkg::fss_cmd_t                 cmd,
	input  logic                              cfg_we,
	input  logic [fss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fss_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [fss_pkg::TIME_W-1:0]        time_now,
	output logic signed [fss_pkg::SMP_W-1:0]  signal,
	output logic [fss_pkg::FREQ_W-1:0]        current_freq,
	output logic                              sweep_active,
	output logic                              sweep_done
);
	import fss_pkg::*;

	localparam int AW = PHASE_INDEX_BITS - 1;
	localparam int RW = PHASE_INDEX_BITS - 2;
	localparam logic [AW-1:0] QUARTER = AW'(1) << RW;
	localparam logic signed [33:0] SAT_HI = (34'sd1 <<< (SAMPLE_WIDTH - 1)) - 34'sd1;
	localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;

	// configuration
	logic [FREQ_W-1:0]        stop_freq_q;
	logic [FREQ_W-1:0]        freq_step_q;
	logic [CPF_W-1:0]         cyc_per_f_q;
	logic signed [SMP_W-1:0]  amplitude_q;
	logic signed [SMP_W-1:0]  bias_q;
	logic [TIME_W-1:0]        start_time_q;

	// sweep state
	logic [FREQ_W-1:0]        freq_now_q;
	logic [TIME_W-1:0]        seg_start_q;
	logic                     finished_q;

	// pipeline
	logic [TIME_W-1:0]        rel_q;
	logic                     ge_q;
	logic [TIME_W-1:0]        elapsed_s1;
	logic                     active_s1;
	logic [63:0]              cyc_s2;
	logic                     neg_s3;
	logic                     reach_s3;
	logic signed [31:0]       prod_s4;
	logic [FREQ_W-1:0]        fsat_s4;
	logic                     le_stop_s4;

	// result
	logic signed [SMP_W-1:0]  signal_q;
	logic [FREQ_W-1:0]        cur_freq_q;
	logic                     active_q;
	logic                     done_q;

	logic [32:0]              rel_w;
	logic [RW-1:0]            r_w;
	logic [1:0]               quad_w;
	logic [AW-1:0]            addr_w;
	logic [COS_W-1:0]         cos_mag;
	logic signed [SMP_W-1:0]  cos_w;
	logic [FREQ_W:0]          fsum_w;
	logic signed [33:0]       rnd_w;
	logic signed [33:0]       sum_w;
	logic signed [33:0]       sat_w;
	logic [FREQ_W-1:0]        freq_nx;
	logic [TIME_W-1:0]        seg_nx;
	logic                     fin_nx;
	logic                     reload_w;

	assign rel_w    = {1'b0, time_now} - {1'b0, start_time_q};
	assign quad_w   = cyc_s2[31:30];
	assign r_w      = cyc_s2[31-2 -: RW];
	assign addr_w   = quad_w[0] ? (QUARTER - {1'b0, r_w}) : {1'b0, r_w};
	assign cos_w    = neg_s3 ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
	assign fsum_w   = {1'b0, freq_now_q} + {1'b0, freq_step_q};
	assign reload_w = cfg_we && (cfg_index == REG_START_FREQ);

	fss_cos_rom #(
		.PHASE_INDEX_BITS(PHASE_INDEX_BITS)
	) u_rom (
		.clk (clk),
		.en  (cmd.rom),
		.addr(addr_w),
		.data(cos_mag)
	);

	always_comb begin
		rnd_w = (34'(prod_s4) + 34'sd8192) >>> 14;
		sum_w = active_s1 ? (rnd_w + 34'(bias_q)) : 34'(bias_q);
		if (sum_w > SAT_HI) begin
			sat_w = SAT_HI;
		end else if (sum_w < SAT_LO) begin
			sat_w = SAT_LO;
		end else begin
			sat_w = sum_w;
		end
		freq_nx = freq_now_q;
		seg_nx  = seg_start_q;
		fin_nx  = finished_q;
		if (active_s1 && reach_s3) begin
			if (le_stop_s4) begin
				seg_nx  = rel_q;
				freq_nx = fsat_s4;
			end else begin
				fin_nx = 1'b1;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rel_q <= rel_w[TIME_W-1:0];
			ge_q  <= !rel_w[TIME_W];
		end
		if (cmd.elap) begin
			elapsed_s1 <= (rel_q >= seg_start_q) ? (rel_q - seg_start_q) : '0;
			active_s1  <= ge_q && !finished_q;
		end
		if (cmd.mul) begin
			cyc_s2 <= 64'(freq_now_q) * 64'(elapsed_s1);
		end
		if (cmd.rom) begin
			neg_s3   <= quad_w[1] ^ quad_w[0];
			reach_s3 <= cyc_s2[63:32] >= 32'(cyc_per_f_q);
		end
		if (cmd.scale) begin
			prod_s4    <= 32'(amplitude_q) * 32'(cos_w);
			fsat_s4    <= fsum_w[FREQ_W] ? '1 : fsum_w[FREQ_W-1:0];
			le_stop_s4 <= freq_now_q <= stop_freq_q;
		end
		if (cmd.fin) begin
			signal_q   <= sat_w[SMP_W-1:0];
			cur_freq_q <= freq_nx;
			active_q   <= active_s1;
			done_q     <= fin_nx;
		end
	end

	// configuration and sweep state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_freq_q  <= STOP_FREQ_RST;
			freq_step_q  <= FREQ_STEP_RST;
			cyc_per_f_q  <= CYC_PER_F_RST;
			amplitude_q  <= AMPLITUDE_RST;
			bias_q       <= BIAS_RST;
			start_time_q <= START_TIME_RST;
			freq_now_q   <= START_FREQ_RST;
			seg_start_q  <= '0;
			finished_q   <= 1'b0;
		end else begin
			if (cmd.fin && !reload_w) begin
				freq_now_q  <= freq_nx;
				seg_start_q <= seg_nx;
				finished_q  <= fin_nx;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_START_FREQ: begin
						freq_now_q   <= cfg_data;
						seg_start_q  <= '0;
						finished_q   <= 1'b0;
					end
					REG_STOP_FREQ:  stop_freq_q  <= cfg_data;
					REG_FREQ_STEP:  freq_step_q  <= cfg_data;
					REG_CYC_PER_F:  cyc_per_f_q  <= cfg_data[CPF_W-1:0];
					REG_AMPLITUDE:  amplitude_q  <= cfg_data[SMP_W-1:0];
					REG_BIAS:       bias_q       <= cfg_data[SMP_W-1:0];
					REG_START_TIME: start_time_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	assign signal       = signal_q;
	assign current_freq = cur_freq_q;
	assign sweep_active = active_q;
	assign sweep_done   = done_q;

	a_finished_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(finished_q && !(cfg_we && cfg_index == REG_START_FREQ)) |=> finished_q)
		else $error("sweep end flag cleared without a start frequency write");

	a_elapsed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.elap |=> (elapsed_s1 <= rel_q))
		else $error("elapsed time exceeds time since start");

	a_idle_freq: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fin && !active_s1) |=> (current_freq == $past(freq_now_q)))
		else $error("frequency moved on an inactive beat");

endmodule

// ===== rtl/fss_ctrl.sv =====
// ----------------------------------------------------------------------------
// fss_ctrl: sweep sequencer
// Steps one beat through elapsed time, multiply, lookup, scale and finish, and
// owns the input ready and the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fss_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output fss_pkg::fss_cmd_t  cmd
);
	import fss_pkg::*;

	fss_state_t state_q;
	fss_state_t state_nx;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_ELAP;
				end
			end
			ST_ELAP: begin
				cmd.elap = 1'b1;
				state_nx = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = ST_ROM;
			end
			ST_ROM: begin
				cmd.rom  = 1'b1;
				state_nx = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_nx  = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.fin  = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_ELAP))
		else $error("accepted beat did not start processing");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while full");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> out_valid_q)
		else $error("finished beat not presented");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

endmodule

// ===== rtl/fra_stepped_sine_sweep.sv =====
// ----------------------------------------------------------------------------
// fra_stepped_sine_sweep: stepped-sine stimulus generator for frequency response
// A beat accepted on the input runs through the elapsed-time, 32x32 phase multiply,
// registered cosine lookup, scaling and finish states in sequence; finish waits while
// the result register is full. No new beat is taken until the last one is finished.
// The result register frees the input once the result is stored.
// Reset: asynchronous, active low; configuration and sweep state take their documented defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fra_stepped_sine_sweep #(
	parameter int PHASE_INDEX_BITS = fss_pkg::PHASE_INDEX_BITS_DEF,
	parameter int SAMPLE_WIDTH     = fss_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fss_pkg::TIME_W-1:0]        time_now,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [fss_pkg::SMP_W-1:0]  signal,
	output logic [fss_pkg::FREQ_W-1:0]        current_freq,
	output logic                              sweep_active,
	output logic                              sweep_done,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fss_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import fss_pkg::*;

	fss_cmd_t cmd;

	assign cfg_ready = 1'b1;

	fss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	fss_datapath #(
		.PHASE_INDEX_BITS(PHASE_INDEX_BITS),
		.SAMPLE_WIDTH    (SAMPLE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.time_now    (time_now),
		.signal      (signal),
		.current_freq(current_freq),
		.sweep_active(sweep_active),
		.sweep_done  (sweep_done)
	);

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stepped-sine sweep generator, self-checking
// Drives time samples through the valid/ready input and compares every result
// beat with typed values or with an in-bench model of the sweep: cosine lookup,
// segment stepping, overshoot, end of sweep and output saturation. A directed
// table covers the extremes and corner cases, then randomised sweeps run under
// random idling, a long receiver hold-off and register rewrites between sweeps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import fss_pkg::*;

	localparam int CLK_PERIOD  = 20;
	localparam int LUT_BITS    = 10;
	localparam int QUARTER     = 1 << (LUT_BITS - 2);
	localparam longint unsigned PI_Q2_30 = 64'd3373259426;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int IDLE_PCT    = 26;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 168;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 3000;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		logic [SMP_W-1:0]  sig;
		logic [FREQ_W-1:0] freq;
		logic              act;
		logic              done;
	} sweep_out_t;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_ITEM,
		ROW_CHECK
	} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  value;
		sweep_out_t             want;
	} plan_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [TIME_W-1:0]            time_now;
	logic                         out_valid;
	logic                         out_ready;
	logic signed [SMP_W-1:0]      signal;
	logic [FREQ_W-1:0]            current_freq;
	logic                         sweep_active;
	logic                         sweep_done;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [CFG_IDX_W-1:0]         cfg_index;
	logic [CFG_DATA_W-1:0]        cfg_data;

	logic [FREQ_W-1:0]            r_start_freq;
	logic [FREQ_W-1:0]            r_stop_freq;
	logic [FREQ_W-1:0]            r_freq_step;
	logic [CPF_W-1:0]             r_cycles;
	logic signed [SMP_W-1:0]      r_amp;
	logic signed [SMP_W-1:0]      r_bias;
	logic [TIME_W-1:0]            r_start_time;
	logic [FREQ_W-1:0]            p_freq;
	logic [TIME_W-1:0]            p_seg_start;
	logic                         p_finished;
	logic signed [15:0]           cos_lut [0:(1<<LUT_BITS)-1];

	sweep_out_t                   expected_out[$];
	plan_row_t                    plan[$];
	int                           mismatches   = 0;
	int                           items_in     = 0;
	int                           hold_at      = 0;
	int                           quiet_cycles = 0;
	logic                         idle_on      = 1'b1;

	fra_stepped_sine_sweep dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.time_now     (time_now),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.signal       (signal),
		.current_freq (current_freq),
		.sweep_active (sweep_active),
		.sweep_done   (sweep_done),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// cos(pi/2 * j/QUARTER) in Q1.14 from a Q2.30 Taylor series
	function automatic int quarter_wave(input int unsigned j);
		longint unsigned theta;
		longint unsigned t2;
		longint unsigned term;
		longint          acc;
		theta = (64'd2 * PI_Q2_30 * 64'(j)) >> LUT_BITS;
		t2    = (theta * theta) >> 30;
		term  = 64'd1 << 30;
		acc   = longint'(term);
		for (int n = 1; n <= 9; n++) begin
			term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
			if ((n % 2) == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		acc = (acc + 32768) >>> 16;
		if (acc > 16384) begin
			acc = 16384;
		end
		return int'(acc);
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_START_FREQ: begin
				r_start_freq = d;
				p_freq       = d;
				p_seg_start  = '0;
				p_finished   = 1'b0;
			end
			REG_STOP_FREQ:  r_stop_freq  = d;
			REG_FREQ_STEP:  r_freq_step  = d;
			REG_CYC_PER_F:  r_cycles     = d[CPF_W-1:0];
			REG_AMPLITUDE:  r_amp        = d[SMP_W-1:0];
			REG_BIAS:       r_bias       = d[SMP_W-1:0];
			REG_START_TIME: r_start_time = d;
			default: ;
		endcase
	endfunction

	function automatic sweep_out_t sweep_predict(input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] rel;
		logic [TIME_W-1:0] elapsed;
		logic [63:0]       cyc;
		logic [32:0]       next_f;
		longint            acc;
		sweep_out_t        res;
		acc     = longint'(r_bias);
		res.act = 1'b0;
		if (t >= r_start_time && !p_finished) begin
			rel     = t - r_start_time;
			elapsed = (rel >= p_seg_start) ? rel - p_seg_start : '0;
			cyc     = 64'(p_freq) * 64'(elapsed);
			acc     = ((longint'(r_amp) * longint'(cos_lut[cyc[31 -: LUT_BITS]]) + 8192) >>> 14)
				+ longint'(r_bias);
			res.act = 1'b1;
			if (cyc[63:32] >= 32'(r_cycles)) begin
				if (p_freq <= r_stop_freq) begin
					p_seg_start = rel;
					next_f      = {1'b0, p_freq} + {1'b0, r_freq_step};
					p_freq      = next_f[32] ? '1 : next_f[31:0];
				end else begin
					p_finished = 1'b1;
				end
			end
		end
		if (acc > 32767) begin
			acc = 32767;
		end else if (acc < -32768) begin
			acc = -32768;
		end
		res.sig  = acc[SMP_W-1:0];
		res.freq = p_freq;
		res.done = p_finished;
		return res;
	endfunction

	function automatic logic idle_gap();
		return idle_on && ($urandom_range(0, 99) < IDLE_PCT);
	endfunction

	// a random step of up to a quarter period at the current frequency, an eighth on average
	function automatic logic [TIME_W-1:0] time_step();
		logic [TIME_W-1:0] span;
		if (p_freq == '0) begin
			return $urandom_range(1, 32'h0001_0000);
		end
		span = 32'h2000_0000 / p_freq;
		if (span == '0) begin
			span = 1;
		end
		return $urandom_range(1, 2 * span);
	endfunction

	function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] d);
		plan_row_t row;
		row       = '0;
		row.kind  = ROW_CFG;
		row.idx   = idx;
		row.value = d;
		plan.push_back(row);
	endfunction

	function automatic void plan_item(input logic [TIME_W-1:0] t);
		plan_row_t row;
		row       = '0;
		row.kind  = ROW_ITEM;
		row.value = t;
		plan.push_back(row);
	endfunction

	function automatic void plan_check(input logic [TIME_W-1:0] t, input logic [SMP_W-1:0] s,
			input logic [FREQ_W-1:0] f, input logic a, input logic d);
		plan_row_t row;
		row       = '0;
		row.kind  = ROW_CHECK;
		row.value = t;
		row.want  = {s, f, a, d};
		plan.push_back(row);
	endfunction

	task automatic send_time(input logic [TIME_W-1:0] t, input logic typed_on,
			input sweep_out_t typed);
		sweep_out_t predicted;
		if (idle_gap()) begin
			in_valid <= 1'b0;
			do @(negedge clk); while (idle_gap());
		end
		in_valid <= 1'b1;
		time_now <= t;
		do @(posedge clk); while (!in_ready);
		predicted = sweep_predict(t);
		expected_out.push_back(typed_on ? typed : predicted);
		items_in++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (expected_out.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure_phase(input int ph);
		logic [31:0] sf;
		logic [31:0] fstep;
		logic [31:0] sp;
		logic [31:0] cyc;
		logic [31:0] amp;
		logic [31:0] bs;
		logic [31:0] t0;
		if (ph == 0) begin
			sf    = '1;
			fstep = '1;
			sp    = '1;
			cyc   = 32'h0000_FFFF;
			amp   = 32'h0000_7FFF;
			bs    = 32'h0000_7FFF;
			t0    = '1;
		end else if (ph == 1) begin
			sf    = '0;
			fstep = '0;
			sp    = '0;
			cyc   = '0;
			amp   = 32'hFFFF_8000;
			bs    = 32'h0000_8000;
			t0    = '0;
		end else begin
			case ($urandom_range(0, 9))
				0:       sf = $urandom();
				1:       sf = $urandom_range(0, 255);
				default: sf = $urandom_range(32'h0001_0000, 32'h03E8_0000);
			endcase
			fstep = ($urandom_range(0, 4) == 0) ? $urandom() : sf >> $urandom_range(0, 3);
			sp    = sf + fstep * $urandom_range(0, 6);
			cyc   = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 3);
			amp   = $urandom();
			bs    = $urandom();
			t0    = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 32'h0010_0000);
		end
		write_reg(REG_STOP_FREQ, sp);
		write_reg(REG_FREQ_STEP, fstep);
		write_reg(REG_CYC_PER_F, cyc);
		write_reg(REG_AMPLITUDE, amp);
		write_reg(REG_BIAS, bs);
		write_reg(REG_START_TIME, t0);
		if ($urandom_range(0, 3) == 0) begin
			write_reg(REG_UNUSED, $urandom());
		end
		write_reg(REG_START_FREQ, sf);
	endtask

	initial begin : receiver
		bit held;
		held      = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && hold_at > 0 && items_in >= hold_at) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready <= !idle_gap();
		end
	end

	always @(posedge clk) begin : check_results
		sweep_out_t got;
		sweep_out_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {signal, current_freq, sweep_active, sweep_done};
			if (expected_out.size() == 0) begin
				$error("result beat with nothing outstanding: signal %0d freq %h",
					signal, current_freq);
				mismatches++;
			end else begin
				want = expected_out.pop_front();
				if (got.sig !== want.sig) begin
					$error("signal: expected %0d, got %0d", $signed(want.sig), $signed(got.sig));
					mismatches++;
				end
				if (got.freq !== want.freq) begin
					$error("current_freq: expected %h, got %h", want.freq, got.freq);
					mismatches++;
				end
				if (got.act !== want.act) begin
					$error("sweep_active: expected %b, got %b", want.act, got.act);
					mismatches++;
				end
				if (got.done !== want.done) begin
					$error("sweep_done: expected %b, got %b", want.done, got.done);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [TIME_W-1:0] t_run;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] off;
		int                pick;
		int                n_directed;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		time_now  = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;

		r_start_freq = 32'd65536;
		r_stop_freq  = 32'd6553600;
		r_freq_step  = 32'd65536;
		r_cycles     = 16'd10;
		r_amp        = 16'sd4096;
		r_bias       = 16'sd0;
		r_start_time = 32'd0;
		p_freq       = r_start_freq;
		p_seg_start  = '0;
		p_finished   = 1'b0;
		for (int k = 0; k < (1 << LUT_BITS); k++) begin
			case (k / QUARTER)
				0:       cos_lut[k] = 16'(quarter_wave(k % QUARTER));
				1:       cos_lut[k] = 16'(-quarter_wave(QUARTER - k % QUARTER));
				2:       cos_lut[k] = 16'(-quarter_wave(k % QUARTER));
				default: cos_lut[k] = 16'(quarter_wave(QUARTER - k % QUARTER));
			endcase
		end

		// reset values, half period, quarter period, segment step, negative elapsed
		plan_check(32'h0000_0000, 16'h1000, 32'h0001_0000, 1'b1, 1'b0);
		plan_check(32'h0000_8000, 16'hF000, 32'h0001_0000, 1'b1, 1'b0);
		plan_item(32'h0000_4000);
		plan_check(32'h000A_0000, 16'h1000, 32'h0002_0000, 1'b1, 1'b0);
		plan_check(32'h0005_0000, 16'h1000, 32'h0002_0000, 1'b1, 1'b0);
		// saturation both ways
		plan_cfg(REG_AMPLITUDE, 32'h0000_7FFF);
		plan_cfg(REG_BIAS, 32'h0000_7FFF);
		plan_check(32'h000A_0000, 16'h7FFF, 32'h0002_0000, 1'b1, 1'b0);
		plan_cfg(REG_AMPLITUDE, 32'hFFFF_8000);
		plan_cfg(REG_BIAS, 32'h0000_8000);
		plan_check(32'h000A_0000, 16'h8000, 32'h0002_0000, 1'b1, 1'b0);
		plan_item(32'h000A_4000);
		// unknown index, time before start, time extremes
		plan_cfg(REG_UNUSED, 32'hFFFF_FFFF);
		plan_cfg(REG_AMPLITUDE, 32'h0000_1000);
		plan_cfg(REG_BIAS, 32'h0000_0400);
		plan_cfg(REG_START_TIME, 32'h0010_0000);
		plan_check(32'h000F_FFFF, 16'h0400, 32'h0002_0000, 1'b0, 1'b0);
		plan_item(32'hFFFF_FFFF);
		plan_item(32'h0010_0000);
		// zero frequency
		plan_cfg(REG_START_FREQ, 32'h0000_0000);
		plan_check(32'hFFFF_FFFF, 16'h1400, 32'h0000_0000, 1'b1, 1'b0);
		// zero periods per frequency
		plan_cfg(REG_CYC_PER_F, 32'h0000_0000);
		plan_cfg(REG_START_FREQ, 32'h0064_0000);
		plan_check(32'h0010_0000, 16'h1400, 32'h0065_0000, 1'b1, 1'b0);
		plan_item(32'h0010_0123);
		// frequency overflow, end of sweep, bias after the end
		plan_cfg(REG_STOP_FREQ, 32'hFFFF_FFFF);
		plan_cfg(REG_FREQ_STEP, 32'hFFFF_FFFF);
		plan_cfg(REG_START_FREQ, 32'hFFFF_0000);
		plan_check(32'h0010_0000, 16'h1400, 32'hFFFF_FFFF, 1'b1, 1'b0);
		plan_check(32'h0010_0000, 16'h1400, 32'hFFFF_FFFF, 1'b1, 1'b0);
		plan_cfg(REG_STOP_FREQ, 32'hFFFF_FFFE);
		plan_check(32'h0010_0000, 16'h1400, 32'hFFFF_FFFF, 1'b1, 1'b1);
		plan_check(32'h0020_0000, 16'h0400, 32'hFFFF_FFFF, 1'b0, 1'b1);
		plan_check(32'h0000_0000, 16'h0400, 32'hFFFF_FFFF, 1'b0, 1'b1);
		// largest period count and frequency, zero step
		plan_cfg(REG_CYC_PER_F, 32'h0000_FFFF);
		plan_cfg(REG_START_TIME, 32'h0000_0000);
		plan_cfg(REG_FREQ_STEP, 32'h0000_0000);
		plan_cfg(REG_STOP_FREQ, 32'hFFFF_FFFF);
		plan_cfg(REG_START_FREQ, 32'hFFFF_FFFF);
		plan_item(32'h0000_FFFF);
		plan_item(32'hFFFF_FFFF);

		n_directed = 0;
		foreach (plan[i]) begin
			if (plan[i].kind != ROW_CFG) begin
				n_directed++;
			end
		end
		hold_at = n_directed + 3 * PHASE_ITEMS + 40;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				drain();
				write_reg(plan[i].idx, plan[i].value);
			end else begin
				send_time(plan[i].value, plan[i].kind == ROW_CHECK, plan[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			idle_on = (ph != 5);
			configure_phase(ph);
			off = time_step() * $urandom_range(0, 3);
			t_run = (r_start_time >= off) ? r_start_time - off : '0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 7 && i == PHASE_ITEMS / 2) begin
					drain();
				end
				pick = $urandom_range(0, 99);
				if (pick < 4) begin
					t = t_run - $urandom_range(1, 32'h0010_0000);
				end else if (pick < 6) begin
					t_run = $urandom();
					t     = t_run;
				end else begin
					t     = t_run;
					t_run = t_run + time_step();
				end
				send_time(t, 1'b0, '0);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/fss_pkg.sv
rtl/fss_cos_rom.sv
rtl/fss_datapath.sv
rtl/fss_ctrl.sv
rtl/fra_stepped_sine_sweep.sv
sim/testbench.sv
